### rtl/core/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants for the YUYV 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  // Q16 conversion coefficients.
  localparam int unsigned CoefW = 17;
  localparam logic [CoefW-1:0] COEF_R_V = 17'd89830;
  localparam logic [CoefW-1:0] COEF_G_V = 17'd45744;
  localparam logic [CoefW-1:0] COEF_G_U = 17'd22127;
  localparam logic [CoefW-1:0] COEF_B_U = 17'd113537;

  // Output scale of 220/256.
  localparam logic [7:0] SCALE_NUM = 8'd220;

  // Widths of the chroma products and the per-channel sums.
  localparam int unsigned ProdW = 25;
  localparam int unsigned SumW  = 27;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } yuyv_word_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } rgb_pair_t;

  // Load enables for the clamp and scale stages of one pixel.
  typedef struct packed {
    logic clamp_ld;
    logic scale_ld;
  } tail_en_t;

endpackage

### rtl/core/yuyv422_to_rgb888_converter.sv
// ----------------------------------------------------------------------------
// yuyv422_to_rgb888_converter
// Converts one packed YUYV 4:2:2 word into two RGB888 pixels per word.
// ----------------------------------------------------------------------------
// The block takes one YUYV word per clock while in_ready is high and returns
// the matching pixel pairs in order. The four register stages
// are: chroma products with Q16 coefficients, per-channel sums with the luma,
// clamp to 0..255, and the 220/256 scale, which is the output register. Each
// stage holds its word only while the stage after it is full and stalled, so
// a stalled output lets earlier stages fill and in_ready drops only when all
// four stages hold words. The frame-end flag travels with its word.
module yuyv422_to_rgb888_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  yrgb_pkg::yuyv_word_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yrgb_pkg::rgb_pair_t  out_data
);

  // Pipeline control.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: chroma products. Flipping the top bit gives the byte minus 128.
  logic signed [7:0] cb_s, cr_s;
  yrgb_pkg::prod_t   p_rv_nxt, p_gv_nxt, p_gu_nxt, p_bu_nxt;
  yrgb_pkg::prod_t   p_rv_r, p_gv_r, p_gu_r, p_bu_r;
  logic [7:0]        y0_r, y1_r;
  logic              fe1_r;

  always_comb begin
    cb_s     = $signed(in_data.chroma_blue ^ 8'h80);
    cr_s     = $signed(in_data.chroma_red  ^ 8'h80);
    p_rv_nxt = $signed({1'b0, yrgb_pkg::COEF_R_V}) * cr_s;
    p_gv_nxt = $signed({1'b0, yrgb_pkg::COEF_G_V}) * cr_s;
    p_gu_nxt = $signed({1'b0, yrgb_pkg::COEF_G_U}) * cb_s;
    p_bu_nxt = $signed({1'b0, yrgb_pkg::COEF_B_U}) * cb_s;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p_rv_r <= p_rv_nxt;
      p_gv_r <= p_gv_nxt;
      p_gu_r <= p_gu_nxt;
      p_bu_r <= p_bu_nxt;
      y0_r   <= in_data.luma_first;
      y1_r   <= in_data.luma_second;
      fe1_r  <= in_data.frame_end_in;
    end
  end

  // Stage 2: luma at Q16 plus or minus the chroma terms.
  yrgb_pkg::sum_t rv_x, gv_x, gu_x, bu_x, base0, base1;
  yrgb_pkg::sum_t r0_nxt, g0_nxt, b0_nxt, r1_nxt, g1_nxt, b1_nxt;
  yrgb_pkg::sum_t r0_r, g0_r, b0_r, r1_r, g1_r, b1_r;
  logic           fe2_r;

  always_comb begin
    rv_x   = {{2{p_rv_r[yrgb_pkg::ProdW-1]}}, p_rv_r};
    gv_x   = {{2{p_gv_r[yrgb_pkg::ProdW-1]}}, p_gv_r};
    gu_x   = {{2{p_gu_r[yrgb_pkg::ProdW-1]}}, p_gu_r};
    bu_x   = {{2{p_bu_r[yrgb_pkg::ProdW-1]}}, p_bu_r};
    base0  = $signed({3'b000, y0_r, 16'h0000});
    base1  = $signed({3'b000, y1_r, 16'h0000});
    r0_nxt = base0 + rv_x;
    g0_nxt = base0 - gv_x - gu_x;
    b0_nxt = base0 + bu_x;
    r1_nxt = base1 + rv_x;
    g1_nxt = base1 - gv_x - gu_x;
    b1_nxt = base1 + bu_x;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      r0_r  <= r0_nxt;
      g0_r  <= g0_nxt;
      b0_r  <= b0_nxt;
      r1_r  <= r1_nxt;
      g1_r  <= g1_nxt;
      b1_r  <= b1_nxt;
      fe2_r <= fe1_r;
    end
  end

  // Stages 3 and 4: clamp and scale, one tail per pixel.
  yrgb_pkg::tail_en_t tail_en;
  logic               fe3_r, fe4_r;

  assign tail_en.clamp_ld = rdy3;
  assign tail_en.scale_ld = rdy4;

  always_ff @(posedge clk) begin
    if (rdy3) fe3_r <= fe2_r;
    if (rdy4) fe4_r <= fe3_r;
  end

  yrgb_pix_tail u_tail_first (
    .clk       (clk),
    .en        (tail_en),
    .red_sum   (r0_r),
    .green_sum (g0_r),
    .blue_sum  (b0_r),
    .red       (out_data.red_first),
    .green     (out_data.green_first),
    .blue      (out_data.blue_first)
  );

  yrgb_pix_tail u_tail_second (
    .clk       (clk),
    .en        (tail_en),
    .red_sum   (r1_r),
    .green_sum (g1_r),
    .blue_sum  (b1_r),
    .red       (out_data.red_second),
    .green     (out_data.green_second),
    .blue      (out_data.blue_second)
  );

  assign out_data.frame_end_out = fe4_r;
  assign out_valid              = v4_r;
  assign in_ready               = rdy1;

`ifndef SYNTH
  // Back-pressure reaches the input only when every stage holds a word.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r && !out_ready))
    else $error("input stalled while the pipeline has a free stage");

  // A word appears in stage two only if stage one held one.
  a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !$past(v2_r)) |-> $past(v1_r))
    else $error("stage two became valid from an empty stage one");

  // Scaled channels never exceed 219.
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_first <= 8'd219 && out_data.green_first <= 8'd219 &&
                   out_data.blue_first <= 8'd219 && out_data.red_second <= 8'd219 &&
                   out_data.green_second <= 8'd219 && out_data.blue_second <= 8'd219))
    else $error("scaled channel above 219");
`endif

endmodule

### rtl/core/yrgb_pix_tail.sv
// ----------------------------------------------------------------------------
// yrgb_pix_tail
// Clamp and scale stages for one RGB pixel: saturate each Q16 sum to 0..255,
// then scale by 220/256 with truncation.
// ----------------------------------------------------------------------------
module yrgb_pix_tail (
  input  logic               clk,
  input  yrgb_pkg::tail_en_t en,
  input  yrgb_pkg::sum_t     red_sum,
  input  yrgb_pkg::sum_t     green_sum,
  input  yrgb_pkg::sum_t     blue_sum,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  logic [7:0]  red_c_r,   green_c_r,   blue_c_r;
  logic [7:0]  red_c_nxt, green_c_nxt, blue_c_nxt;
  logic [15:0] red_p,     green_p,     blue_p;
  logic [7:0]  red_r,     green_r,     blue_r;

  // A negative sum goes to zero; anything at or above 256.0 saturates.
  function automatic logic [7:0] clamp8(yrgb_pkg::sum_t acc);
    logic [7:0] c;
    if (acc[yrgb_pkg::SumW-1]) begin
      c = 8'd0;
    end else if (|acc[yrgb_pkg::SumW-2:24]) begin
      c = 8'd255;
    end else begin
      c = acc[23:16];
    end
    return c;
  endfunction

  always_comb begin
    red_c_nxt   = clamp8(red_sum);
    green_c_nxt = clamp8(green_sum);
    blue_c_nxt  = clamp8(blue_sum);
    red_p       = 16'(red_c_r)   * 16'(yrgb_pkg::SCALE_NUM);
    green_p     = 16'(green_c_r) * 16'(yrgb_pkg::SCALE_NUM);
    blue_p      = 16'(blue_c_r)  * 16'(yrgb_pkg::SCALE_NUM);
  end

  always_ff @(posedge clk) begin
    if (en.clamp_ld) begin
      red_c_r   <= red_c_nxt;
      green_c_r <= green_c_nxt;
      blue_c_r  <= blue_c_nxt;
    end
    if (en.scale_ld) begin
      red_r   <= red_p[15:8];
      green_r <= green_p[15:8];
      blue_r  <= blue_p[15:8];
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the YUYV 4:2:2 to RGB888 converter word by word. Each accepted YUYV
// word is converted by a Q16 integer predictor in the bench, and every pixel
// pair that comes out is compared with the oldest pending prediction. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 2000;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 20;

  typedef struct {
    yrgb_pkg::yuyv_word_t word;
    bit                   drain_first;
  } send_entry_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  yrgb_pkg::yuyv_word_t in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  yrgb_pkg::rgb_pair_t  out_data;

  send_entry_t         words_to_send[$];
  yrgb_pkg::rgb_pair_t pairs_due[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap    = 0;
  int  take_gap    = 0;
  bit  in_calm     = 1'b0;
  bit  out_calm    = 1'b0;

  yuyv422_to_rgb888_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Floor of a Q16 sum, clamped to 0..255, then scaled by 220/256.
  function automatic logic [7:0] video_level(longint acc);
    longint c;
    if (acc < 0) return 8'd0;
    c = acc >>> 16;
    if (c > 255) c = 255;
    return 8'((c * longint'(yrgb_pkg::SCALE_NUM)) >> 8);
  endfunction

  function automatic yrgb_pkg::rgb_pair_t convert_word(yrgb_pkg::yuyv_word_t w);
    longint              cb;
    longint              cr;
    longint              r_term;
    longint              g_term;
    longint              b_term;
    longint              y0;
    longint              y1;
    yrgb_pkg::rgb_pair_t p;
    cb     = longint'(w.chroma_blue) - 128;
    cr     = longint'(w.chroma_red) - 128;
    r_term = longint'(yrgb_pkg::COEF_R_V) * cr;
    g_term = -(longint'(yrgb_pkg::COEF_G_V) * cr) - longint'(yrgb_pkg::COEF_G_U) * cb;
    b_term = longint'(yrgb_pkg::COEF_B_U) * cb;
    y0     = longint'(w.luma_first) <<< 16;
    y1     = longint'(w.luma_second) <<< 16;
    p.red_first     = video_level(y0 + r_term);
    p.green_first   = video_level(y0 + g_term);
    p.blue_first    = video_level(y0 + b_term);
    p.red_second    = video_level(y1 + r_term);
    p.green_second  = video_level(y1 + g_term);
    p.blue_second   = video_level(y1 + b_term);
    p.frame_end_out = w.frame_end_in;
    return p;
  endfunction

  function automatic string pair_text(yrgb_pkg::rgb_pair_t p);
    return $sformatf("(%0d,%0d,%0d) (%0d,%0d,%0d) end=%0b", p.red_first, p.green_first,
                     p.blue_first, p.red_second, p.green_second, p.blue_second,
                     p.frame_end_out);
  endfunction

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Leans toward the values around the chroma offset and the byte limits.
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: presents one word at a time and records its prediction when taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) pairs_due.push_back(convert_word(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (words_to_send.size() == 0 ||
                     (words_to_send[0].drain_first && pairs_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_data  <= words_to_send[0].word;
          in_valid <= 1'b1;
          void'(words_to_send.pop_front());
          if ($urandom_range(0, 149) == 0) in_calm <= !in_calm;
          send_gap <= pick_gap(in_calm);
        end
      end
    end
  end

  // Monitor: checks each pixel pair taken and throttles out_ready.
  always @(posedge clk) begin : result_monitor
    yrgb_pkg::rgb_pair_t want;
    bit                  bad;
    int                  gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pairs_due.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("tb_top: unexpected word %s", pair_text(out_data));
        end else begin
          want = pairs_due.pop_front();
          bad = (out_data.red_first !== want.red_first) ||
                (out_data.green_first !== want.green_first) ||
                (out_data.blue_first !== want.blue_first) ||
                (out_data.red_second !== want.red_second) ||
                (out_data.green_second !== want.green_second) ||
                (out_data.blue_second !== want.blue_second) ||
                (out_data.frame_end_out !== want.frame_end_out);
          if (bad) begin
            error_count++;
            if (error_count <= 10)
              $display("tb_top: mismatch expected %s got %s", pair_text(want),
                       pair_text(out_data));
          end
        end
        if ($urandom_range(0, 149) == 0) out_calm <= !out_calm;
        // A zero gap keeps out_ready high so results can be taken back to back.
        gap = pick_gap(out_calm);
        take_gap  <= gap;
        out_ready <= (gap == 0);
      end else if (take_gap > 0) begin
        out_ready <= 1'b0;
        take_gap  <= take_gap - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    send_entry_t e;
    logic [7:0]  luma_picks[2]   = '{8'd0, 8'd255};
    logic [7:0]  chroma_picks[3] = '{8'd0, 8'd128, 8'd255};

    // Directed words: luma and chroma extremes, which drive channels below
    // zero and past 255, plus the neutral gray point.
    e.drain_first = 1'b0;
    foreach (luma_picks[i]) begin
      foreach (chroma_picks[j]) begin
        foreach (chroma_picks[k]) begin
          e.word.luma_first   = luma_picks[i];
          e.word.chroma_blue  = chroma_picks[j];
          e.word.luma_second  = ~luma_picks[i];
          e.word.chroma_red   = chroma_picks[k];
          e.word.frame_end_in = 1'((j + k) % 2);
          words_to_send.push_back(e);
        end
      end
    end
    e.word = '{8'd128, 8'd128, 8'd128, 8'd128, 1'b1};
    words_to_send.push_back(e);
    e.word = '{8'd16, 8'd128, 8'd235, 8'd128, 1'b0};
    words_to_send.push_back(e);

    for (int n = 0; n < RandomWords; n++) begin
      e.drain_first       = (n == 0) || (n == RandomWords / 2);
      e.word.luma_first   = pick_byte();
      e.word.chroma_blue  = pick_byte();
      e.word.luma_second  = pick_byte();
      e.word.chroma_red   = pick_byte();
      e.word.frame_end_in = ($urandom_range(0, 15) == 0);
      words_to_send.push_back(e);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_valid || pairs_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (pairs_due.size() != 0) begin
      error_count += pairs_due.size();
      $display("tb_top: %0d words never arrived", pairs_due.size());
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
